@@ hw/rtl/ffba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, widths and defaults of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int POOL_BYTES_DEF   = 1024 * 1024;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam int REQ_W    = 21;   // request size field
    localparam int ADDR_W   = 20;   // payload offset field
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 21;   // pool offsets, 0 .. pool size

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_OOM     = 3'd2,
        ST_FULL    = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_SET_NULL,
        DP_SET_UNKNOWN,
        DP_SCAN_READ,
        DP_SCAN_STEP,
        DP_ALLOC_HIT,
        DP_APPEND,
        DP_FREE_HIT,
        DP_NEXT_READ,
        DP_NEXT_MERGE,
        DP_PREV_READ,
        DP_PREV_MERGE,
        DP_MARK_FREE,
        DP_SHIFT_READ,
        DP_SHIFT_WRITE,
        DP_SHIFT_DONE
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_APPEND,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_PREV_RD,
        S_PREV_CHK,
        S_MARK,
        S_SH_RD,
        S_SH_WR,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;     // request is a free
        logic zero_req;    // allocate of zero bytes
        logic null_addr;   // free of address zero
        logic scan_end;    // pointer has reached the block count
        logic alloc_fit;   // entry read is free and large enough
        logic addr_match;  // entry read starts at the freed address
        logic rd_free;     // free mark of the entry read
        logic at_first;    // merge base is entry zero
        logic shift_done;  // nothing left to move down
        logic out_busy;    // output register holds a result not yet taken
    } t_dp_stat;

    typedef struct packed {
        logic              free;
        logic [ADDR_W-1:0] size;
    } t_entry;

endpackage
`default_nettype wire

@@ hw/rtl/ffba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer of the allocator: walks the block table and issues datapath
// commands for allocate, free, merge and table compaction.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = DP_NONE;
        o_cmd.emit = 1'b0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (i_stat.zero_req || i_stat.null_addr) begin
                    o_cmd.op = DP_SET_NULL;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    if (i_stat.is_free) begin
                        o_cmd.op = DP_SET_UNKNOWN;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    o_cmd.op = DP_SCAN_READ;
                    n_state  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_stat.is_free && i_stat.alloc_fit) begin
                    o_cmd.op = DP_ALLOC_HIT;
                    n_state  = S_RESULT;
                end else if (i_stat.is_free && i_stat.addr_match) begin
                    o_cmd.op = DP_FREE_HIT;
                    n_state  = S_NEXT_RD;
                end else begin
                    o_cmd.op = DP_SCAN_STEP;
                    n_state  = S_SCAN_RD;
                end
            end
            S_APPEND: begin
                o_cmd.op = DP_APPEND;
                n_state  = S_RESULT;
            end
            S_NEXT_RD: begin
                if (i_stat.scan_end) begin
                    n_state = S_PREV_RD;
                end else begin
                    o_cmd.op = DP_NEXT_READ;
                    n_state  = S_NEXT_CHK;
                end
            end
            S_NEXT_CHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.op = DP_NEXT_MERGE;
                end
                n_state = S_PREV_RD;
            end
            S_PREV_RD: begin
                if (i_stat.at_first) begin
                    n_state = S_MARK;
                end else begin
                    o_cmd.op = DP_PREV_READ;
                    n_state  = S_PREV_CHK;
                end
            end
            S_PREV_CHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.op = DP_PREV_MERGE;
                end
                n_state = S_MARK;
            end
            S_MARK: begin
                o_cmd.op = DP_MARK_FREE;
                n_state  = S_SH_RD;
            end
            S_SH_RD: begin
                if (i_stat.shift_done) begin
                    o_cmd.op = DP_SHIFT_DONE;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.op = DP_SHIFT_READ;
                    n_state  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.op = DP_SHIFT_WRITE;
                n_state  = S_SH_RD;
            end
            S_RESULT: begin
                // hold until the output register can take the result
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/ffba_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, scan pointer and offset, break, block count, merge
// registers and the output register of the allocator.
// ----------------------------------------------------------------------------
module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = POOL_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_operation,
    input  wire logic [REQ_W-1:0]  i_request_size,
    input  wire logic [ADDR_W-1:0] i_block_address,
    input  wire logic              i_out_ready,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_out_valid,
    output logic [STATUS_W-1:0]    o_status,
    output logic [ADDR_W-1:0]      o_result_address
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = REQ_W + 2;

    localparam logic [SUM_W-1:0] HDR_S  = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] POOL_S = SUM_W'(POOL_BYTES);
    localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_BLOCKS);

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd;

    // request
    logic              r_op;
    logic [REQ_W-1:0]  r_size;
    logic [ADDR_W-1:0] r_addr;

    // table walk and pool state
    logic [CNT_W-1:0]  r_idx;
    logic [OFF_W-1:0]  r_offset;
    logic [CNT_W-1:0]  r_count;
    logic [OFF_W-1:0]  r_break;

    // merge
    logic [ADDR_W-1:0] r_acc;
    logic [IDX_W-1:0]  r_base;
    logic [1:0]        r_shift;

    // result and output register
    t_status           r_res_status;
    logic [ADDR_W-1:0] r_res_addr;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_addr;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    logic [SUM_W-1:0]  off_hdr;
    logic [SUM_W-1:0]  off_next;
    logic [SUM_W-1:0]  brk_hdr;
    logic [SUM_W-1:0]  brk_end;
    logic [SUM_W-1:0]  acc_next;
    logic [SUM_W-1:0]  acc_prev;
    logic [CNT_W:0]    shift_idx;
    logic              oom;
    logic              full;

    always_comb begin
        off_hdr   = SUM_W'(r_offset) + HDR_S;
        off_next  = off_hdr + SUM_W'(r_rd.size);
        brk_hdr   = SUM_W'(r_break) + HDR_S;
        brk_end   = brk_hdr + SUM_W'(r_size);
        acc_next  = SUM_W'(r_acc) + HDR_S + SUM_W'(r_rd.size);
        acc_prev  = SUM_W'(r_rd.size) + HDR_S + SUM_W'(r_acc);
        shift_idx = (CNT_W + 1)'(r_idx) + (CNT_W + 1)'(r_shift);
        oom       = brk_end > POOL_S;
        full      = r_count >= MAX_C;
    end

    always_comb begin
        o_stat.is_free    = r_op;
        o_stat.zero_req   = !r_op && (r_size == '0);
        o_stat.null_addr  = r_op && (r_addr == '0);
        o_stat.scan_end   = (r_idx == r_count);
        o_stat.alloc_fit  = r_rd.free && (REQ_W'(r_rd.size) >= r_size);
        o_stat.addr_match = (off_hdr == SUM_W'(r_addr));
        o_stat.rd_free    = r_rd.free;
        o_stat.at_first   = (r_base == '0);
        o_stat.shift_done = (r_shift == 2'd0) || (shift_idx >= (CNT_W + 1)'(r_count));
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = r_rd;
        case (i_cmd.op)
            DP_SCAN_READ, DP_NEXT_READ: begin
                rd_en = 1'b1;
            end
            DP_PREV_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_base - 1'b1;
            end
            DP_SHIFT_READ: begin
                rd_en   = 1'b1;
                rd_addr = shift_idx[IDX_W-1:0];
            end
            DP_ALLOC_HIT: begin
                wr_en        = 1'b1;
                wr_data.free = 1'b0;
                wr_data.size = r_rd.size;
            end
            DP_APPEND: begin
                wr_en        = !oom && !full;
                wr_addr      = r_count[IDX_W-1:0];
                wr_data.free = 1'b0;
                wr_data.size = r_size[ADDR_W-1:0];
            end
            DP_MARK_FREE: begin
                wr_en        = 1'b1;
                wr_addr      = r_base;
                wr_data.free = 1'b1;
                wr_data.size = r_acc;
            end
            DP_SHIFT_WRITE: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_break <= '0;
        end else begin
            case (i_cmd.op)
                DP_APPEND: begin
                    if (!oom && !full) begin
                        r_count <= r_count + 1'b1;
                        r_break <= brk_end[OFF_W-1:0];
                    end
                end
                DP_SHIFT_DONE: begin
                    r_count <= r_count - CNT_W'(r_shift);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // request, walk and merge registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_op     <= i_operation;
                r_size   <= i_request_size;
                r_addr   <= i_block_address;
                r_idx    <= '0;
                r_offset <= '0;
            end
            DP_SET_NULL: begin
                r_res_status <= ST_NULL;
                r_res_addr   <= '0;
            end
            DP_SET_UNKNOWN: begin
                r_res_status <= ST_UNKNOWN;
                r_res_addr   <= '0;
            end
            DP_SCAN_STEP: begin
                r_idx    <= r_idx + 1'b1;
                r_offset <= off_next[OFF_W-1:0];
            end
            DP_ALLOC_HIT: begin
                r_res_status <= ST_OK;
                r_res_addr   <= off_hdr[ADDR_W-1:0];
            end
            DP_APPEND: begin
                if (oom) begin
                    r_res_status <= ST_OOM;
                    r_res_addr   <= '0;
                end else if (full) begin
                    r_res_status <= ST_FULL;
                    r_res_addr   <= '0;
                end else begin
                    r_res_status <= ST_OK;
                    r_res_addr   <= brk_hdr[ADDR_W-1:0];
                end
            end
            DP_FREE_HIT: begin
                r_acc   <= r_rd.size;
                r_base  <= r_idx[IDX_W-1:0];
                r_shift <= 2'd0;
                r_idx   <= r_idx + 1'b1;
            end
            DP_NEXT_MERGE: begin
                r_acc   <= acc_next[ADDR_W-1:0];
                r_shift <= 2'd1;
            end
            DP_PREV_MERGE: begin
                r_acc   <= acc_prev[ADDR_W-1:0];
                r_base  <= r_base - 1'b1;
                r_shift <= r_shift + 1'b1;
            end
            DP_MARK_FREE: begin
                r_idx        <= CNT_W'(r_base) + 1'b1;
                r_res_status <= ST_OK;
                r_res_addr   <= '0;
            end
            DP_SHIFT_WRITE: begin
                r_idx <= r_idx + 1'b1;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_address = r_out_addr;

endmodule
`default_nettype wire

@@ hw/rtl/first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Use: one request enters on i_in_valid / o_in_ready (operation, request size,
// block address) and one result leaves on o_out_valid / i_out_ready (status,
// result address). A request is taken when valid and ready are both high.
// Table: the block table sits in a memory with separate read and write ports
// and a registered read, so each visited entry takes a read state and a
// check state. An allocate walks entries up to the first fit, a free up to
// and including its block and then moves entries down after a merge.
// Zero-size and null requests skip the walk. One request is worked at a
// time; the next one is taken as soon as the result sits in the output
// register.
// Reset: the table is empty and the break is zero; entries are only read
// below the block count, so no clearing pass runs and the block is ready in
// the first cycle after reset.
// Stall: a result waits in the output register while i_out_ready is low; a
// following request is still taken and worked, then holds until that
// register is free.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = POOL_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_operation,
    input  wire logic [REQ_W-1:0]  i_request_size,
    input  wire logic [ADDR_W-1:0] i_block_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [ADDR_W-1:0]      o_result_address
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: walk, merge and compaction control
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // table memory, pool arithmetic and output register
    ffba_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_operation),
        .i_request_size   (i_request_size),
        .i_block_address  (i_block_address),
        .i_out_ready      (i_out_ready),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_result_address (o_result_address)
    );

    // a taken request always loads the datapath
    a_accept_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (w_cmd.op == DP_LOAD))
        else $error("request taken without loading the datapath");

    // the sequencer is busy in the cycle after a request is taken
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready high right after a request was taken");

    // a result never overwrites one that has not been taken
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(o_out_valid && !i_out_ready))
        else $error("result emitted into a full output register");

    // results with a failing status report a zero address
    a_fail_zero_addr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_result_address == '0))
        else $error("non-zero address with a failing status");

endmodule
`default_nettype wire

@@ tb/sv/tb_first_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A directed table
// covers null, zero-size, unknown-address and out-of-pool requests, block
// reuse, double frees and neighbour merging. Random traffic then swings the
// block table between filling up to the table limit and draining it, and
// finally pushes the break to the very end of the pool. Every result is
// compared with an in-bench model of the block table, under random idling,
// a long result stall and one full drain of outstanding results.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int POOL            = POOL_BYTES_DEF;
    localparam int HDR             = HEADER_BYTES_DEF;
    localparam int BLOCKS          = MAX_BLOCKS_DEF;
    localparam int N_DIRECTED      = 22;
    localparam int RANDOM_REQUESTS = 626;
    localparam int STEADY_FROM     = 150;       // no idling on either side from here ...
    localparam int STEADY_TO       = 250;       // ... up to here
    localparam int PAUSE_AT        = 450;       // sender waits for every result here
    localparam int STALL_AT_RESULT = 300;
    localparam int STALL_CYCLES    = 500;
    localparam int DRAIN_CYCLES    = 4 * BLOCKS + 40;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int MAX_REPORTS     = 40;

    typedef enum bit { OP_ALLOC = 1'b0, OP_FREE = 1'b1 } t_op;
    typedef enum bit { MODE_FILL, MODE_DRAIN } t_mode;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
    } t_outcome;

    typedef struct packed {
        t_op               op;
        logic [REQ_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        logic              typed;   // use the outcome below instead of the model
        t_outcome          want;
    } t_stim;

    // Directed requests. Rows with typed set carry their outcome; the rest are
    // checked against the block-table model.
    localparam t_stim DIRECTED [N_DIRECTED] = '{
        '{OP_ALLOC, 21'd0,       20'd0,     1'b1, '{ST_NULL,    20'd0}},   // zero size
        '{OP_FREE,  21'd0,       20'd0,     1'b1, '{ST_NULL,    20'd0}},   // null free
        '{OP_FREE,  21'd0,       20'd24,    1'b1, '{ST_UNKNOWN, 20'd0}},   // empty table
        '{OP_ALLOC, 21'h1FFFFF,  20'hFFFFF, 1'b1, '{ST_OOM,     20'd0}},   // all size bits
        '{OP_ALLOC, 21'd1048576, 20'd0,     1'b1, '{ST_OOM,     20'd0}},   // whole pool
        '{OP_ALLOC, 21'd1,       20'd0,     1'b1, '{ST_OK,      20'd24}},
        '{OP_ALLOC, 21'd100,     20'd0,     1'b1, '{ST_OK,      20'd49}},
        '{OP_ALLOC, 21'd200,     20'd0,     1'b1, '{ST_OK,      20'd173}},
        '{OP_FREE,  21'h1FFFFF,  20'hFFFFF, 1'b1, '{ST_UNKNOWN, 20'd0}},   // all address bits
        '{OP_FREE,  21'd0,       20'd50,    1'b1, '{ST_UNKNOWN, 20'd0}},   // inside a payload
        '{OP_FREE,  21'd0,       20'd173,   1'b0, '{ST_OK,      20'd0}},   // trailing block
        '{OP_ALLOC, 21'd150,     20'd0,     1'b0, '{ST_OK,      20'd0}},   // reuse it whole
        '{OP_FREE,  21'd0,       20'd49,    1'b0, '{ST_OK,      20'd0}},
        '{OP_FREE,  21'd0,       20'd49,    1'b0, '{ST_OK,      20'd0}},   // double free
        '{OP_ALLOC, 21'd101,     20'd0,     1'b0, '{ST_OK,      20'd0}},   // one byte too big
        '{OP_ALLOC, 21'd100,     20'd0,     1'b0, '{ST_OK,      20'd0}},   // exact fit
        '{OP_FREE,  21'd0,       20'd24,    1'b0, '{ST_OK,      20'd0}},
        '{OP_FREE,  21'd0,       20'd49,    1'b0, '{ST_OK,      20'd0}},   // merge with left
        '{OP_FREE,  21'd0,       20'd173,   1'b0, '{ST_OK,      20'd0}},   // merge again
        '{OP_FREE,  21'd0,       20'd49,    1'b0, '{ST_OK,      20'd0}},   // swallowed block
        '{OP_ALLOC, 21'd349,     20'd0,     1'b0, '{ST_OK,      20'd0}},   // merged size
        '{OP_ALLOC, 21'd1048576, 20'd0,     1'b1, '{ST_OOM,     20'd0}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_operation;
    logic [REQ_W-1:0]  i_request_size;
    logic [ADDR_W-1:0] i_block_address;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [ADDR_W-1:0] o_result_address;

    // Block-table model
    logic [ADDR_W-1:0] blk_size [BLOCKS];
    bit                blk_free [BLOCKS];
    int                blk_count  = 0;
    longint            pool_break = 0;

    t_outcome expected_results [$];
    int       status_tally [5] = '{default: 0};
    int       requests_taken = 0;
    int       results_seen   = 0;
    int       mismatches     = 0;
    int       swings         = 0;
    int       cycles         = 0;
    int       stall_left     = 0;
    bit       stall_done     = 1'b0;
    bit       steady         = 1'b0;
    t_mode    mode           = MODE_FILL;

    first_fit_block_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_request_size   (i_request_size),
        .i_block_address  (i_block_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_result_address (o_result_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the block-table model and return its outcome.
    function automatic t_outcome allocator_outcome(t_op op, logic [REQ_W-1:0] size,
                                                   logic [ADDR_W-1:0] addr);
        t_outcome res;
        longint   offset;
        int       i;
        int       j;
        offset = 0;
        if (op == OP_ALLOC) begin
            if (size == '0)
                return '{ST_NULL, '0};
            // first fit: reuse the whole block, never split it
            for (i = 0; i < blk_count; i++) begin
                if (blk_free[i] && blk_size[i] >= size) begin
                    blk_free[i] = 1'b0;
                    return '{ST_OK, ADDR_W'(offset + HDR)};
                end
                offset += HDR + blk_size[i];
            end
            // the pool check comes before the table check
            if (pool_break + HDR + size > POOL)
                return '{ST_OOM, '0};
            if (blk_count >= BLOCKS)
                return '{ST_FULL, '0};
            blk_size[blk_count] = ADDR_W'(size);
            blk_free[blk_count] = 1'b0;
            blk_count++;
            res = '{ST_OK, ADDR_W'(pool_break + HDR)};
            pool_break += HDR + size;
            return res;
        end
        if (addr == '0)
            return '{ST_NULL, '0};
        for (i = 0; i < blk_count; i++) begin
            if (offset + HDR == addr) begin
                blk_free[i] = 1'b1;
                // fold each pair of free neighbours into the first, header included
                i = 0;
                while (i + 1 < blk_count) begin
                    if (blk_free[i] && blk_free[i+1]) begin
                        blk_size[i] = blk_size[i] + ADDR_W'(HDR) + blk_size[i+1];
                        for (j = i + 1; j + 1 < blk_count; j++) begin
                            blk_size[j] = blk_size[j+1];
                            blk_free[j] = blk_free[j+1];
                        end
                        blk_count--;
                    end else begin
                        i++;
                    end
                end
                return '{ST_OK, '0};
            end
            offset += HDR + blk_size[i];
        end
        return '{ST_UNKNOWN, '0};
    endfunction

    // Draw a random request, biased by the current mode towards filling or
    // draining the table. Frees mostly name real blocks.
    function automatic t_stim random_request();
        t_stim             req;
        longint            busy_at [$];
        longint            idle_at [$];
        logic [ADDR_W-1:0] idle_len [$];
        longint            offset;
        int                i;
        int                roll;
        offset = 0;
        for (i = 0; i < blk_count; i++) begin
            if (blk_free[i]) begin
                idle_at.push_back(offset + HDR);
                idle_len.push_back(blk_size[i]);
            end else begin
                busy_at.push_back(offset + HDR);
            end
            offset += HDR + blk_size[i];
        end
        req.typed = 1'b0;
        req.want  = '0;
        req.size  = REQ_W'($urandom);    // ignored by a free
        req.addr  = ADDR_W'($urandom);   // ignored by an allocate
        roll = $urandom_range(99, 0);
        req.op = (roll < ((mode == MODE_FILL) ? 15 : 70)) ? OP_FREE : OP_ALLOC;
        roll = $urandom_range(99, 0);
        if (req.op == OP_ALLOC) begin
            if (roll < 3)
                req.size = '0;
            else if (roll < 6)
                req.size = REQ_W'($urandom_range(2097151, 1048576));
            else if (roll < 10)
                req.size = REQ_W'($urandom_range(16383, 1024));
            else if (roll < 25 && idle_len.size() > 0)
                // exact fit, or one byte more than a free block holds
                req.size = REQ_W'(idle_len[$urandom_range(idle_len.size() - 1, 0)])
                         + REQ_W'($urandom_range(1, 0));
            else if (roll < 55)
                req.size = REQ_W'($urandom_range(1023, 1));
            else
                req.size = REQ_W'($urandom_range(255, 1));
        end else begin
            if (roll < 4)
                req.addr = '0;
            else if (roll < 14 && busy_at.size() > 0)
                req.addr = ADDR_W'(busy_at[$urandom_range(busy_at.size() - 1, 0)] + 1);
            else if (roll < 24 && idle_at.size() > 0)
                req.addr = ADDR_W'(idle_at[$urandom_range(idle_at.size() - 1, 0)]);
            else if (roll >= 30 && busy_at.size() > 0)
                req.addr = ADDR_W'(busy_at[$urandom_range(busy_at.size() - 1, 0)]);
            else
                req.addr = ADDR_W'($urandom_range(20'hFFFFF, 1));
        end
        return req;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH on result %0d: %s", $time, results_seen, what);
    endtask

    // Offer one request, hold it until taken, then record what it should give.
    task automatic offer_request(input t_stim req, output t_outcome outcome);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99, 0) < 20)
                gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= req.op;
        i_request_size  <= req.size;
        i_block_address <= req.addr;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        outcome = allocator_outcome(req.op, req.size, req.addr);
        expected_results.push_back(req.typed ? req.want : outcome);
        requests_taken++;
    endtask

    task automatic take_result();
        t_outcome want;
        results_seen++;
        if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, status %0d address 0x%05h",
                                    o_status, o_result_address));
            return;
        end
        want = expected_results.pop_front();
        status_tally[want.status]++;
        if (o_status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
        if (o_result_address !== want.addr)
            flag_mismatch($sformatf("address 0x%05h, want 0x%05h",
                                    o_result_address, want.addr));
    endtask

    // Result side: check on each handshake, idle at random, and hold off
    // once for a long stretch so that the request side backs up.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
                take_result();
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!stall_done && results_seen >= STALL_AT_RESULT) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99, 0) >= 20);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycles, expected_results.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_stim    req;
        t_outcome got;
        int       k;
        int       mode_items;
        int       full_hits;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_operation     <= OP_ALLOC;
        i_request_size  <= '0;
        i_block_address <= '0;
        mode_items = 0;
        full_hits  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            offer_request(DIRECTED[k], got);

        // Random traffic. Fill until the table has refused three requests or 200 were
        // offered, then drain until at most three blocks remain or 200 were offered, and repeat.
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            steady = (k >= STEADY_FROM && k < STEADY_TO);
            if (k == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
            end
            req = random_request();
            offer_request(req, got);
            mode_items++;
            if (mode == MODE_FILL) begin
                if (got.status == ST_FULL)
                    full_hits++;
                if (full_hits >= 3 || mode_items >= 200) begin
                    mode       = MODE_DRAIN;
                    mode_items = 0;
                    swings++;
                end
            end else if (blk_count <= 3 || mode_items >= 200) begin
                mode       = MODE_FILL;
                mode_items = 0;
                full_hits  = 0;
                swings++;
            end
        end

        // Push the break to the end of the pool: one byte too many, then an exact fit.
        for (k = 1; k >= 0; k--) begin
            if (pool_break + HDR < POOL) begin
                req = '{OP_ALLOC, REQ_W'(POOL - pool_break - HDR + k), '0, 1'b0, '0};
                offer_request(req, got);
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d results: %0d ok, %0d zero/null, %0d out of pool,",
                 requests_taken, results_seen, status_tally[ST_OK], status_tally[ST_NULL],
                 status_tally[ST_OOM]);
        $display("%0d table full, %0d unknown address; %0d fill/drain swings, %0d mismatches.",
                 status_tally[ST_FULL], status_tally[ST_UNKNOWN], swings, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
